>>> rtl/wkdc_pkg.sv
// shared types and constants for the at-most-k-distinct window counter
// no dependencies; imported by every module of the block
package wkdc_pkg;

  localparam int ITEM_BITS  = 32;
  localparam int POS_BITS   = 32;
  localparam int TOTAL_BITS = 64;
  localparam int CFG_BITS   = 5;

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [CFG_BITS-1:0]   limit_cfg_t;

  // what one cell hands to the next one down the chain
  typedef struct packed {
    logic valid;  // the sending cell holds a live entry
    logic seen;   // the incoming value matched a cell above this point
  } link_ctrl_t;

  // per-cell command from the top level
  typedef struct packed {
    logic load;      // a transaction is taken this cycle
    logic flush;     // start of a new sequence, treat the table as empty
    logic keep;      // this cell index lies below the distinct limit
    logic at_limit;  // this cell index equals the distinct limit
  } cell_cmd_t;

endpackage

>>> rtl/wkdc_cell.sv
// one entry of the recency-ordered table: value, last position, valid
// depends on wkdc_pkg; chained in the top level, cell 0 holds the newest value
module wkdc_cell import wkdc_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] key,
  input  link_ctrl_t            up_ctrl,
  input  logic [VALUE_BITS-1:0] up_value,
  input  pos_t                  up_last,
  output link_ctrl_t            down_ctrl,
  output logic [VALUE_BITS-1:0] down_value,
  output pos_t                  down_last,
  output logic                  evict_valid,
  output pos_t                  evict_last
);

  logic                  valid;
  logic [VALUE_BITS-1:0] value;
  pos_t                  last;

  logic                  cur_valid;
  logic                  match;
  logic                  upd_valid;
  logic [VALUE_BITS-1:0] upd_value;
  pos_t                  upd_last;

  // live entry and compare against the incoming value
  assign cur_valid = valid & ~cmd.flush;
  assign match     = cur_valid & (value == key);

  // shift down unless the hit sits above this cell
  always_comb begin
    if (!up_ctrl.seen) begin
      upd_valid = up_ctrl.valid;
      upd_value = up_value;
      upd_last  = up_last;
    end else begin
      upd_valid = cur_valid;
      upd_value = value;
      upd_last  = last;
    end
  end

  // hand the old contents to the next cell
  assign down_ctrl.valid = cur_valid;
  assign down_ctrl.seen  = up_ctrl.seen | match;
  assign down_value      = value;
  assign down_last       = last;

  // the entry at the limit index is the youngest one dropped
  assign evict_valid = upd_valid & cmd.at_limit;
  assign evict_last  = upd_last;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.load) begin
      valid <= upd_valid & cmd.keep;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value <= upd_value;
      last  <= upd_last;
    end
  end

endmodule

>>> rtl/window_at_most_k_distinct_count.sv
// running count of subarrays holding at most k distinct values
// path: a taken transaction passes the first stage, second stage and output registers
// throughput: one transaction per cycle while out_ready does not stall the stages
// reset: synchronous, clears table, position, window start and total; k resets to 1
// depends on wkdc_pkg and wkdc_cell
module window_at_most_k_distinct_count import wkdc_pkg::*; #(
  parameter int MAX_DISTINCT = 16,
  parameter int VALUE_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  limit_cfg_t            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ITEM_BITS-1:0]  item_value,
  input  logic                  first_of_sequence,
  output logic                  out_valid,
  input  logic                  out_ready,
  output total_t                running_total,
  output pos_t                  window_length
);

  localparam int STORE_BITS = (VALUE_BITS < ITEM_BITS) ? VALUE_BITS : ITEM_BITS;
  localparam int LIMIT_BITS = $clog2(MAX_DISTINCT + 1);

  logic [LIMIT_BITS-1:0] limit;
  logic                  limit_zero;
  logic [STORE_BITS-1:0] key;
  logic                  in_fire;
  pos_t                  pos;
  pos_t                  next_position;

  link_ctrl_t            link_ctrl  [0:MAX_DISTINCT];
  logic [STORE_BITS-1:0] link_value [0:MAX_DISTINCT];
  pos_t                  link_last  [0:MAX_DISTINCT];
  logic                  cell_evict_valid [0:MAX_DISTINCT-1];
  pos_t                  cell_evict_last  [0:MAX_DISTINCT-1];
  logic                  tail_evict;
  logic                  evict_any;
  pos_t                  evict_pos;

  logic                  out_take;
  logic                  s2_free;
  logic                  s2_move;
  logic                  s1_move;

  logic                  s1_valid;
  pos_t                  s1_pos;
  logic                  s1_kzero;
  logic                  s1_first;
  logic                  s1_evict_valid;
  pos_t                  s1_evict_last;

  pos_t                  window_start;
  pos_t                  ws_next;
  pos_t                  span;
  pos_t                  length_next;
  logic                  s2_valid;
  pos_t                  s2_length;
  logic                  s2_first;

  total_t                total_base;
  logic [TOTAL_BITS:0]   total_sum;
  total_t                total_next;

  // distinct limit, clamped to the table size on write
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_BITS'(1);
    end else if (cfg_wr_en) begin
      if (int'(cfg_wr_data) > MAX_DISTINCT) begin
        limit <= LIMIT_BITS'(MAX_DISTINCT);
      end else begin
        limit <= LIMIT_BITS'(cfg_wr_data);
      end
    end
  end

  assign limit_zero = (limit == '0);
  assign key        = item_value[STORE_BITS-1:0];
  assign in_fire    = in_valid & in_ready;
  assign pos        = first_of_sequence ? '0 : next_position;

  // handshake between stages
  assign out_take = ~out_valid | out_ready;
  assign s2_move  = s2_valid & out_take;
  assign s2_free  = ~s2_valid | out_take;
  assign s1_move  = s1_valid & s2_free;
  assign in_ready = ~s1_valid | s2_free;

  // head of the chain is the incoming value
  assign link_ctrl[0]  = '{valid: 1'b1, seen: 1'b0};
  assign link_value[0] = key;
  assign link_last[0]  = pos;

  // row of table cells, newest first
  for (genvar i = 0; i < MAX_DISTINCT; i++) begin : g_cell
    cell_cmd_t cmd;

    assign cmd.load     = in_fire;
    assign cmd.flush    = first_of_sequence;
    assign cmd.keep     = (limit > LIMIT_BITS'(i));
    assign cmd.at_limit = (limit == LIMIT_BITS'(i));

    wkdc_cell #(
      .VALUE_BITS(STORE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .key        (key),
      .up_ctrl    (link_ctrl[i]),
      .up_value   (link_value[i]),
      .up_last    (link_last[i]),
      .down_ctrl  (link_ctrl[i+1]),
      .down_value (link_value[i+1]),
      .down_last  (link_last[i+1]),
      .evict_valid(cell_evict_valid[i]),
      .evict_last (cell_evict_last[i])
    );
  end

  // entry pushed off the end of a full table on a miss
  assign tail_evict = link_ctrl[MAX_DISTINCT].valid & ~link_ctrl[MAX_DISTINCT].seen &
                      (limit == LIMIT_BITS'(MAX_DISTINCT));

  // pick the youngest dropped entry, at most one cell reports it
  always_comb begin
    evict_any = tail_evict;
    evict_pos = tail_evict ? link_last[MAX_DISTINCT] : '0;
    for (int i = 0; i < MAX_DISTINCT; i++) begin
      evict_any = evict_any | cell_evict_valid[i];
      evict_pos = evict_pos | (cell_evict_last[i] & {POS_BITS{cell_evict_valid[i]}});
    end
  end

  // sequence position
  always_ff @(posedge clk) begin
    if (rst) begin
      next_position <= '0;
    end else if (in_fire) begin
      next_position <= pos + 1'b1;
    end
  end

  // first stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire | (s1_valid & ~s1_move);
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos         <= pos;
      s1_kzero       <= limit_zero;
      s1_first       <= first_of_sequence;
      s1_evict_valid <= evict_any;
      s1_evict_last  <= evict_pos;
    end
  end

  // new window start and window length
  always_comb begin
    if (s1_kzero) begin
      ws_next = s1_pos + 1'b1;
    end else if (s1_evict_valid) begin
      ws_next = s1_evict_last + 1'b1;
    end else if (s1_first) begin
      ws_next = '0;
    end else begin
      ws_next = window_start;
    end
    span = s1_pos - ws_next;
    if (s1_kzero) begin
      length_next = '0;
    end else if (&span) begin
      length_next = '1;
    end else begin
      length_next = span + 1'b1;
    end
  end

  // window start register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
    end else if (s1_move) begin
      window_start <= ws_next;
    end
  end

  // second stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_move | (s2_valid & ~s2_move);
    end
  end

  // second stage payload
  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_length <= length_next;
      s2_first  <= s1_first;
    end
  end

  // saturating total
  always_comb begin
    total_base = s2_first ? '0 : running_total;
    total_sum  = {1'b0, total_base} + (TOTAL_BITS+1)'(s2_length);
    total_next = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
  end

  // output register, the total doubles as the running state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      running_total <= '0;
    end else begin
      out_valid <= s2_move | (out_valid & ~out_ready);
      if (s2_move) begin
        running_total <= total_next;
      end
    end
  end

  // output length
  always_ff @(posedge clk) begin
    if (s2_move) begin
      window_length <= s2_length;
    end
  end

endmodule

>>> rtl/wkdc_checker.sv
// port-level checks for the at-most-k-distinct window counter
// depends on wkdc_pkg; bound to window_at_most_k_distinct_count below
module wkdc_checker import wkdc_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input total_t running_total,
  input pos_t   window_length
);

  // nothing shown right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a free output side never blocks the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // a transaction reaches the output when the output drains
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing after transaction");

  // the total always includes the current window
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running_total >= total_t'(window_length)))
    else $error("running total below window length");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_total) &&
    $stable(window_length))
    else $error("stalled result changed");

endmodule

bind window_at_most_k_distinct_count wkdc_checker u_wkdc_checker (.*);

>>> test/wkdc_tb_pkg.sv
// scoreboard for the at-most-k-distinct window counter testbench
// holds its own copy of the slot table and predicts total and window length
// depends on wkdc_pkg for the port types
`timescale 1ns / 100ps

package wkdc_tb_pkg;
  import wkdc_pkg::*;

  localparam int TALLY_SLOTS = 16;
  localparam total_t TOTAL_MAX = '1;

  class window_tally;
    typedef struct {
      total_t total;
      pos_t   length;
    } window_result_t;

    // predicted slot table and sequence state
    bit                   live[TALLY_SLOTS];
    logic [ITEM_BITS-1:0] held_value[TALLY_SLOTS];
    pos_t                 seen_at[TALLY_SLOTS];
    pos_t                 next_pos;
    pos_t                 win_start;
    total_t               total;
    limit_cfg_t           limit;

    window_result_t pending_windows[$];
    int unsigned    items_noted;
    int unsigned    results_checked;
    int unsigned    sequences;
    int unsigned    errors;

    function new();
      items_noted = 0;
      results_checked = 0;
      sequences = 0;
      errors = 0;
      reset_all();
    endfunction

    function void clear_sequence();
      foreach (live[i]) live[i] = 1'b0;
      next_pos = '0;
      win_start = '0;
      total = '0;
    endfunction

    function void reset_all();
      clear_sequence();
      limit = 5'd1;
      pending_windows.delete();
    endfunction

    function void set_limit(limit_cfg_t v);
      limit = v;
    endfunction

    function int unsigned live_count();
      int unsigned n;
      n = 0;
      foreach (live[i]) if (live[i]) n++;
      return n;
    endfunction

    // evict the live slot seen longest ago, window start moves past it
    function void drop_oldest(pos_t pos);
      int   victim;
      pos_t age;
      pos_t best;
      victim = -1;
      best = '0;
      foreach (live[i]) begin
        if (live[i]) begin
          age = pos - seen_at[i];
          if (victim < 0 || age > best) begin
            victim = i;
            best = age;
          end
        end
      end
      if (victim >= 0) begin
        live[victim] = 1'b0;
        win_start = seen_at[victim] + 1;
      end
    endfunction

    // predict the result of one accepted transaction
    function void note_item(logic [ITEM_BITS-1:0] v, logic first);
      int             hit;
      bit             placed;
      int unsigned    k;
      pos_t           pos;
      pos_t           span;
      pos_t           len;
      window_result_t r;
      hit = -1;
      placed = 1'b0;
      len = '0;
      if (first) begin
        clear_sequence();
        sequences++;
      end
      k = (limit > TALLY_SLOTS) ? TALLY_SLOTS : limit;
      pos = next_pos;
      if (k == 0) begin
        // nothing may be counted, table empties and window moves past this item
        foreach (live[i]) live[i] = 1'b0;
        win_start = pos + 1;
      end else begin
        foreach (live[i]) if (hit < 0 && live[i] && held_value[i] == v) hit = i;
        if (hit >= 0) begin
          seen_at[hit] = pos;
          while (live_count() > k) drop_oldest(pos);
        end else begin
          while (live_count() >= k) drop_oldest(pos);
          foreach (live[i]) begin
            if (!placed && !live[i]) begin
              live[i] = 1'b1;
              held_value[i] = v;
              seen_at[i] = pos;
              placed = 1'b1;
            end
          end
        end
        span = pos - win_start;
        len = (span == '1) ? span : span + 1;
        // saturating total
        if (total > TOTAL_MAX - total_t'(len)) total = TOTAL_MAX;
        else total = total + total_t'(len);
      end
      next_pos = pos + 1;
      r.total = total;
      r.length = len;
      pending_windows.push_back(r);
      items_noted++;
    endfunction

    // compare one accepted result against the oldest prediction
    function void check_result(total_t t, pos_t l);
      window_result_t r;
      if (pending_windows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, total %0d length %0d", $time, t, l);
        return;
      end
      r = pending_windows.pop_front();
      results_checked++;
      if (t !== r.total) begin
        errors++;
        $display("%0t: running_total expected %0d actual %0d", $time, r.total, t);
      end
      if (l !== r.length) begin
        errors++;
        $display("%0t: window_length expected %0d actual %0d", $time, r.length, l);
      end
    endfunction
  endclass

endpackage

>>> test/testbench.sv
// top-level testbench for window_at_most_k_distinct_count
// drives directed and random value streams with idling and stalls, checks every result
// depends on wkdc_pkg, wkdc_tb_pkg and the block's RTL
`timescale 1ns / 100ps

module testbench;
  import wkdc_pkg::*;
  import wkdc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  limit_cfg_t           cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [ITEM_BITS-1:0] item_value;
  logic                 first_of_sequence;
  logic                 out_valid;
  logic                 out_ready;
  total_t               running_total;
  pos_t                 window_length;

  window_tally tally;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned limit_writes = 0;

  window_at_most_k_distinct_count #(
    .MAX_DISTINCT(TALLY_SLOTS),
    .VALUE_BITS(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .item_value(item_value),
    .first_of_sequence(first_of_sequence),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .running_total(running_total),
    .window_length(window_length)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one value, with an optional idle burst first, and wait until taken
  task automatic send_value(input logic [ITEM_BITS-1:0] v, input logic first);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    item_value <= v;
    first_of_sequence <= first;
    do @(posedge clk); while (!in_ready);
    tally.note_item(v, first);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tally.pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write k only once the block has drained
  task automatic set_distinct_limit(input limit_cfg_t v);
    wait_for_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tally.set_limit(v);
    limit_writes++;
  endtask

  // result side: check accepted transactions, stall in bursts or one long hold
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) tally.check_result(running_total, window_length);
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 4);
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    limit_cfg_t           extremes[4];
    limit_cfg_t           lim;
    logic [ITEM_BITS-1:0] base;
    logic [ITEM_BITS-1:0] v;
    logic                 first;
    int unsigned          alphabet;
    extremes = '{5'd16, 5'd0, 5'd31, 5'd1};
    tally = new();
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    item_value <= '0;
    first_of_sequence <= 1'b0;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // k of one after reset, extreme values
    send_value('0, 1'b1);
    send_value('1, 1'b0);
    send_value('1, 1'b0);
    send_value('0, 1'b0);

    // k zero counts nothing
    set_distinct_limit(5'd0);
    send_value(32'd7, 1'b1);
    send_value(32'd7, 1'b0);

    // k above table size, more distinct values than slots
    set_distinct_limit(5'd31);
    for (int i = 0; i < 17; i++) send_value(32'hA5A5_0000 + i, i == 0);

    // k lowered mid-sequence, then a hit and a new value
    set_distinct_limit(5'd2);
    send_value(32'hA5A5_0010, 1'b0);
    send_value(32'h0000_1234, 1'b0);

    // random phases, mostly repeats from a small alphabet
    for (int p = 0; p < PHASES; p++) begin
      lim = (p < 4) ? extremes[p] : limit_cfg_t'($urandom_range(1, 31));
      set_distinct_limit(lim);
      if (p == PHASES - 1) idle_on = 1'b0;
      alphabet = $urandom_range(1, 24);
      base = $urandom;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (p == 0 && j == 20) hold_req = 1'b1;
        first = (j == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 49) == 0);
        v = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, alphabet - 1);
        send_value(v, first);
      end
    end

    wait_for_results();
    $display("sent %0d transactions in %0d sequences across %0d settings of k",
             tally.items_noted, tally.sequences, limit_writes);
    $display("checked %0d results, %0d field errors", tally.results_checked, tally.errors);
    if (tally.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
